// ===== hdl/ffha_pkg.sv =====
// Shared types, widths and codes of the first-fit heap allocator.
`timescale 1ns / 1ps
package ffha_pkg;

    localparam int ADDR_W   = 32;
    localparam int SIZE_W   = 24;
    localparam int STATUS_W = 3;
    localparam int ENTRY_W  = SIZE_W + ADDR_W;   // {size, address}
    localparam int CMP_W    = ADDR_W + 1;        // room for the break + header + size carry

    localparam int S_TDATA_W = 56;               // request_size, block_address
    localparam int M_TDATA_W = 40;               // granted_address, status, zero fill

    // request kinds carried on s_tuser
    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NULL    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_OOM     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_UNKNOWN = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd4;

    // register index, taken from paddr[2]
    localparam logic REG_HEAP_START = 1'b0;
    localparam logic REG_HEAP_END   = 1'b1;

    typedef struct packed {
        logic [ADDR_W-1:0] heap_start;
        logic [ADDR_W-1:0] heap_end;
    } cfg_regs_t;

    typedef struct packed {
        logic eq;
        logic gt;
    } cmp_res_t;

endpackage

// ===== hdl/ffha_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps
module ffha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                         aclk,
    input  logic                                         we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                             wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                             rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/ffha_cfg.sv =====
// APB register file holding the heap bounds.
`timescale 1ns / 1ps
module ffha_cfg
    import ffha_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output cfg_regs_t         cfg
);

    cfg_regs_t cfg_reg;
    cfg_regs_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (psel && penable && pwrite) begin
            case (paddr[2])
                REG_HEAP_START: cfg_next.heap_start = pwdata;
                REG_HEAP_END:   cfg_next.heap_end   = pwdata;
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        case (paddr[2])
            REG_HEAP_START: prdata = cfg_reg.heap_start;
            REG_HEAP_END:   prdata = cfg_reg.heap_end;
            default:        prdata = '0;
        endcase
    end

    assign pready = 1'b1;
    assign cfg    = cfg_reg;

endmodule

// ===== hdl/ffha_cmp.sv =====
// Shared magnitude comparator used for size fit, address match and heap limit.
`timescale 1ns / 1ps
module ffha_cmp
    import ffha_pkg::*;
(
    input  logic [CMP_W-1:0] a,
    input  logic [CMP_W-1:0] b,
    output cmp_res_t         res
);

    assign res.eq = (a == b);
    assign res.gt = (a > b);

endmodule

// ===== hdl/ffha_seq.sv =====
// Request sequencer: live table scan, free list walk and compaction, heap bump.
`timescale 1ns / 1ps
module ffha_seq
    import ffha_pkg::*;
#(
    parameter int FREE_SLOTS   = 16,
    parameter int LIVE_SLOTS   = 16,
    parameter int HEADER_BYTES = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  cfg_regs_t             cfg,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  logic                  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata
);

    localparam int LIDX_W = (LIVE_SLOTS > 1) ? $clog2(LIVE_SLOTS) : 1;
    localparam int FIDX_W = (FREE_SLOTS > 1) ? $clog2(FREE_SLOTS) : 1;
    localparam int CNT_W  = $clog2(FREE_SLOTS + 1);

    localparam logic [LIDX_W-1:0] LIVE_LAST = LIDX_W'(LIVE_SLOTS - 1);
    localparam logic [CNT_W-1:0]  FREE_FULL = CNT_W'(FREE_SLOTS);
    localparam logic [CNT_W-1:0]  CNT_ONE   = CNT_W'(1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_LSCAN = 4'd1;   // find an empty live slot
    localparam logic [3:0] S_FRD   = 4'd2;   // read free entry
    localparam logic [3:0] S_FCHK  = 4'd3;   // size fit check
    localparam logic [3:0] S_SRD   = 4'd4;   // compaction read
    localparam logic [3:0] S_SWR   = 4'd5;   // compaction write
    localparam logic [3:0] S_BUMP  = 4'd6;   // grow the break
    localparam logic [3:0] S_MRD   = 4'd7;   // read live entry
    localparam logic [3:0] S_MCHK  = 4'd8;   // address match check
    localparam logic [3:0] S_DONE  = 4'd9;

    logic [3:0]             state_reg, state_next;
    logic [SIZE_W-1:0]      size_reg, size_next;
    logic [ADDR_W-1:0]      addr_reg, addr_next;
    logic [LIDX_W-1:0]      li_reg, li_next;
    logic [LIDX_W-1:0]      slot_reg, slot_next;
    logic [CNT_W-1:0]       fi_reg, fi_next;     // newest-first walk, entry fi-1
    logic [CNT_W-1:0]       j_reg, j_next;
    logic [CNT_W-1:0]       fcount_reg, fcount_next;
    logic [ADDR_W-1:0]      bp_reg, bp_next;
    logic [LIVE_SLOTS-1:0]  valid_reg, valid_next;
    logic [ADDR_W-1:0]      res_addr_reg, res_addr_next;
    logic [STATUS_W-1:0]    res_status_reg, res_status_next;
    logic                   m_valid_reg, m_valid_next;
    logic [ADDR_W-1:0]      m_addr_reg, m_addr_next;
    logic [STATUS_W-1:0]    m_status_reg, m_status_next;

    logic                   free_we;
    logic [FIDX_W-1:0]      free_waddr, free_raddr;
    logic [ENTRY_W-1:0]     free_wdata, free_rdata;
    logic                   live_we;
    logic [LIDX_W-1:0]      live_waddr, live_raddr;
    logic [ENTRY_W-1:0]     live_wdata, live_rdata;

    logic [CMP_W-1:0]       cmp_a, cmp_b;
    cmp_res_t               cmp_res;

    logic [ADDR_W-1:0]      bp_eff;
    logic [CMP_W-1:0]       top;
    logic [ADDR_W-1:0]      granted;
    logic [CNT_W:0]         j_plus2;

    ffha_ram #(.WIDTH(ENTRY_W), .DEPTH(FREE_SLOTS)) u_free_ram (
        .aclk  (aclk),
        .we    (free_we),
        .waddr (free_waddr),
        .wdata (free_wdata),
        .raddr (free_raddr),
        .rdata (free_rdata)
    );

    ffha_ram #(.WIDTH(ENTRY_W), .DEPTH(LIVE_SLOTS)) u_live_ram (
        .aclk  (aclk),
        .we    (live_we),
        .waddr (live_waddr),
        .wdata (live_wdata),
        .raddr (live_raddr),
        .rdata (live_rdata)
    );

    ffha_cmp u_cmp (
        .a   (cmp_a),
        .b   (cmp_b),
        .res (cmp_res)
    );

    // a zero break means not yet loaded
    assign bp_eff  = (bp_reg == '0) ? cfg.heap_start : bp_reg;
    assign top     = {1'b0, bp_eff} + CMP_W'(HEADER_BYTES) + CMP_W'(size_reg);
    assign granted = bp_eff + ADDR_W'(HEADER_BYTES);
    assign j_plus2 = {1'b0, j_reg} + (CNT_W + 1)'(2);

    always_comb begin
        case (state_reg)
            S_FCHK: begin
                cmp_a = CMP_W'(free_rdata[ENTRY_W-1:ADDR_W]);
                cmp_b = CMP_W'(size_reg);
            end
            S_MCHK: begin
                cmp_a = {1'b0, live_rdata[ADDR_W-1:0]};
                cmp_b = {1'b0, addr_reg};
            end
            default: begin
                cmp_a = top;
                cmp_b = {1'b0, cfg.heap_end};
            end
        endcase
    end

    always_comb begin
        state_next      = state_reg;
        size_next       = size_reg;
        addr_next       = addr_reg;
        li_next         = li_reg;
        slot_next       = slot_reg;
        fi_next         = fi_reg;
        j_next          = j_reg;
        fcount_next     = fcount_reg;
        bp_next         = bp_reg;
        valid_next      = valid_reg;
        res_addr_next   = res_addr_reg;
        res_status_next = res_status_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_addr_next     = m_addr_reg;
        m_status_next   = m_status_reg;

        free_we    = 1'b0;
        free_waddr = fcount_reg[FIDX_W-1:0];
        free_wdata = {live_rdata[ENTRY_W-1:ADDR_W], addr_reg};
        free_raddr = FIDX_W'(fi_reg - CNT_ONE);
        live_we    = 1'b0;
        live_waddr = slot_reg;
        live_wdata = {size_reg, granted};
        live_raddr = li_reg;
        s_tready   = 1'b0;

        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    size_next       = s_tdata[SIZE_W-1:0];
                    addr_next       = s_tdata[SIZE_W +: ADDR_W];
                    li_next         = '0;
                    res_addr_next   = '0;
                    res_status_next = ST_OK;
                    if (s_tuser == REQ_ALLOC) begin
                        if (s_tdata[SIZE_W-1:0] == '0) begin
                            res_status_next = ST_NULL;
                            state_next      = S_DONE;
                        end else begin
                            state_next = S_LSCAN;
                        end
                    end else begin
                        if (s_tdata[SIZE_W +: ADDR_W] == '0) begin
                            res_status_next = ST_NULL;
                            state_next      = S_DONE;
                        end else begin
                            state_next = S_MRD;
                        end
                    end
                end
            end
            S_LSCAN: begin
                if (!valid_reg[li_reg]) begin
                    slot_next = li_reg;
                    fi_next   = fcount_reg;
                    state_next = (fcount_reg == '0) ? S_BUMP : S_FRD;
                end else if (li_reg == LIVE_LAST) begin
                    res_status_next = ST_FULL;
                    state_next      = S_DONE;
                end else begin
                    li_next = li_reg + LIDX_W'(1);
                end
            end
            S_FRD: begin
                state_next = S_FCHK;
            end
            S_FCHK: begin
                if (cmp_res.gt || cmp_res.eq) begin
                    live_we                = 1'b1;
                    live_wdata             = free_rdata;
                    valid_next[slot_reg]   = 1'b1;
                    res_addr_next          = free_rdata[ADDR_W-1:0];
                    res_status_next        = ST_OK;
                    j_next                 = fi_reg - CNT_ONE;
                    if (fi_reg < fcount_reg) begin
                        state_next = S_SRD;
                    end else begin
                        fcount_next = fcount_reg - CNT_ONE;
                        state_next  = S_DONE;
                    end
                end else if (fi_reg == CNT_ONE) begin
                    state_next = S_BUMP;
                end else begin
                    fi_next    = fi_reg - CNT_ONE;
                    state_next = S_FRD;
                end
            end
            S_SRD: begin
                free_raddr = FIDX_W'(j_reg + CNT_ONE);
                state_next = S_SWR;
            end
            S_SWR: begin
                free_we    = 1'b1;
                free_waddr = FIDX_W'(j_reg);
                free_wdata = free_rdata;
                j_next     = j_reg + CNT_ONE;
                if (j_plus2 < {1'b0, fcount_reg}) begin
                    state_next = S_SRD;
                end else begin
                    fcount_next = fcount_reg - CNT_ONE;
                    state_next  = S_DONE;
                end
            end
            S_BUMP: begin
                if (cmp_res.gt) begin
                    bp_next         = bp_eff;
                    res_status_next = ST_OOM;
                end else begin
                    bp_next              = top[ADDR_W-1:0];
                    live_we              = 1'b1;
                    valid_next[slot_reg] = 1'b1;
                    res_addr_next        = granted;
                    res_status_next      = ST_OK;
                end
                state_next = S_DONE;
            end
            S_MRD: begin
                if (valid_reg[li_reg]) begin
                    state_next = S_MCHK;
                end else if (li_reg == LIVE_LAST) begin
                    res_status_next = ST_UNKNOWN;
                    state_next      = S_DONE;
                end else begin
                    li_next = li_reg + LIDX_W'(1);
                end
            end
            S_MCHK: begin
                if (cmp_res.eq) begin
                    if (fcount_reg == FREE_FULL) begin
                        res_status_next = ST_FULL;
                    end else begin
                        free_we            = 1'b1;
                        fcount_next        = fcount_reg + CNT_ONE;
                        valid_next[li_reg] = 1'b0;
                        res_status_next    = ST_OK;
                    end
                    state_next = S_DONE;
                end else if (li_reg == LIVE_LAST) begin
                    res_status_next = ST_UNKNOWN;
                    state_next      = S_DONE;
                end else begin
                    li_next    = li_reg + LIDX_W'(1);
                    state_next = S_MRD;
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next  = 1'b1;
                    m_addr_next   = res_addr_reg;
                    m_status_next = res_status_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            fcount_reg  <= '0;
            bp_reg      <= '0;
            valid_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            fcount_reg  <= fcount_next;
            bp_reg      <= bp_next;
            valid_reg   <= valid_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        size_reg       <= size_next;
        addr_reg       <= addr_next;
        li_reg         <= li_next;
        slot_reg       <= slot_next;
        fi_reg         <= fi_next;
        j_reg          <= j_next;
        res_addr_reg   <= res_addr_next;
        res_status_reg <= res_status_next;
        m_addr_reg     <= m_addr_next;
        m_status_reg   <= m_status_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - ADDR_W - STATUS_W){1'b0}}, m_status_reg, m_addr_reg};

endmodule

// ===== hdl/first_fit_heap_allocator_top.sv =====
// Top level of the first-fit heap allocator: APB registers and request sequencer.
`timescale 1ns / 1ps
// First-fit heap allocator. Each beat on the s_ side is one request (s_tuser 0 allocate,
// 1 free) and gives exactly one result beat on the m_ side. Allocate takes the newest
// free-list block whose size covers the request, whole, else grows the break by
// HEADER_BYTES plus the size; free moves a live block onto the free list. Requests are
// handled one at a time by a sequencer around one shared comparator and two RAMs with
// registered reads. Allocate scans the live table for an empty slot, then walks the free
// list newest first, checking each entry's size, moves the newer entries down to close the
// gap left by a taken entry, or else bumps the break. Free searches the occupied live
// slots for the address. No clearing pass is needed after reset.
// heap_start is at byte address 0, heap_end at 4.
module first_fit_heap_allocator_top
    import ffha_pkg::*;
#(
    parameter int FREE_SLOTS   = 16,
    parameter int LIVE_SLOTS   = 16,
    parameter int HEADER_BYTES = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [23:0] request_size, [55:24] block_address
    input  logic                 s_tuser,   // [0] req_type
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // [31:0] granted_address, [34:32] status
);

    cfg_regs_t cfg;

    ffha_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ffha_seq #(
        .FREE_SLOTS   (FREE_SLOTS),
        .LIVE_SLOTS   (LIVE_SLOTS),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// ===== tb/sv/tb_first_fit_heap_allocator_top.sv =====
// Self-checking testbench for the first-fit heap allocator: directed table, then random traffic.
`timescale 1ns / 1ps
module tb_first_fit_heap_allocator_top
    import ffha_pkg::*;
();

    localparam int FREE_SLOTS   = 16;
    localparam int LIVE_SLOTS   = 16;
    localparam int HEADER_BYTES = 8;
    localparam int STALL_LIMIT  = 20000;
    localparam int DRAIN_CYCLES = 120;
    localparam int HOLD_CYCLES  = 400;
    localparam int MAX_PRINTS   = 50;
    localparam int DIR_ROWS     = 24;

    localparam logic [2:0]    ADDR_HEAP_START = {REG_HEAP_START, 2'b00};
    localparam logic [2:0]    ADDR_HEAP_END   = {REG_HEAP_END, 2'b00};
    localparam logic [ADDR_W:0] HDR_WIDE      = (ADDR_W + 1)'(HEADER_BYTES);

    typedef enum logic [1:0] { ROW_REQ, ROW_SET_START, ROW_SET_END } row_op_e;

    typedef struct packed {
        logic [ADDR_W-1:0]   granted;
        logic [STATUS_W-1:0] status;
    } heap_res_t;

    typedef struct packed {
        row_op_e           op;
        logic              kind;
        logic [SIZE_W-1:0] size;
        logic [ADDR_W-1:0] word;    // block address, or register value
        logic              typed;   // res holds a hand-written expectation
        heap_res_t         res;
    } plan_row_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [2:0]           paddr;
    logic [31:0]          pwdata;
    logic [31:0]          prdata;
    logic                 pready;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;   // [23:0] request_size, [55:24] block_address
    logic                 s_tuser;   // [0] req_type
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;   // [31:0] granted_address, [34:32] status

    first_fit_heap_allocator_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Allocator shadow state
    logic [ADDR_W-1:0] cfg_start = '0;
    logic [ADDR_W-1:0] cfg_end   = '0;
    logic [ADDR_W-1:0] brk       = '0;
    logic [ADDR_W-1:0] free_addr [FREE_SLOTS];
    logic [SIZE_W-1:0] free_size [FREE_SLOTS];
    int                free_cnt  = 0;
    logic [ADDR_W-1:0] live_addr [LIVE_SLOTS];
    logic [SIZE_W-1:0] live_size [LIVE_SLOTS];
    bit                live_ok   [LIVE_SLOTS];

    heap_res_t awaited_results [$];
    int        errors        = 0;
    int        quiet_cycles  = 0;
    int        hold_len      = 0;
    int        send_idle_pct = 16;
    int        recv_idle_pct = 84;
    plan_row_t plan [DIR_ROWS];

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // One allocate or free applied to the shadow state; returns the result beat it gives.
    function automatic heap_res_t apply_request(logic kind, logic [SIZE_W-1:0] size,
                                                logic [ADDR_W-1:0] addr);
        heap_res_t       r;
        int              slot;
        int              hit;
        int              i;
        logic [ADDR_W:0] top;
        r.granted = '0;
        r.status  = ST_OK;
        slot = -1;
        hit  = -1;
        if (kind == REQ_ALLOC) begin
            if (size == '0) begin
                r.status = ST_NULL;
                return r;
            end
            for (i = LIVE_SLOTS - 1; i >= 0; i--)
                if (!live_ok[i]) slot = i;
            if (slot < 0) begin
                r.status = ST_FULL;
                return r;
            end
            // newest free entry first
            for (i = free_cnt - 1; i >= 0 && hit < 0; i--)
                if (free_size[i] >= size) hit = i;
            if (hit >= 0) begin
                r.granted       = free_addr[hit];
                live_size[slot] = free_size[hit];
                for (i = hit; i < free_cnt - 1; i++) begin
                    free_addr[i] = free_addr[i+1];
                    free_size[i] = free_size[i+1];
                end
                free_cnt--;
            end else begin
                if (brk == '0) brk = cfg_start;
                top = {1'b0, brk} + HDR_WIDE + {{(ADDR_W+1-SIZE_W){1'b0}}, size};
                if (top > {1'b0, cfg_end}) begin
                    r.status = ST_OOM;
                    return r;
                end
                r.granted       = brk + HEADER_BYTES;
                brk             = top[ADDR_W-1:0];
                live_size[slot] = size;
            end
            live_addr[slot] = r.granted;
            live_ok[slot]   = 1'b1;
        end else begin
            if (addr == '0) begin
                r.status = ST_NULL;
                return r;
            end
            for (i = LIVE_SLOTS - 1; i >= 0; i--)
                if (live_ok[i] && live_addr[i] == addr) hit = i;
            if (hit < 0) begin
                r.status = ST_UNKNOWN;
            end else if (free_cnt >= FREE_SLOTS) begin
                r.status = ST_FULL;
            end else begin
                free_addr[free_cnt] = addr;
                free_size[free_cnt] = live_size[hit];
                free_cnt++;
                live_ok[hit] = 1'b0;
            end
        end
        return r;
    endfunction

    function automatic plan_row_t ask(logic kind, logic [SIZE_W-1:0] size,
                                      logic [ADDR_W-1:0] word);
        plan_row_t r;
        r      = '0;
        r.op   = ROW_REQ;
        r.kind = kind;
        r.size = size;
        r.word = word;
        return r;
    endfunction

    function automatic plan_row_t ask_for(logic kind, logic [SIZE_W-1:0] size,
                                          logic [ADDR_W-1:0] word, logic [ADDR_W-1:0] granted,
                                          logic [STATUS_W-1:0] status);
        plan_row_t r;
        r             = ask(kind, size, word);
        r.typed       = 1'b1;
        r.res.granted = granted;
        r.res.status  = status;
        return r;
    endfunction

    function automatic plan_row_t set_reg(row_op_e op, logic [ADDR_W-1:0] value);
        plan_row_t r;
        r      = '0;
        r.op   = op;
        r.word = value;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        errors++;
        if (errors <= MAX_PRINTS)
            $display("%0t: %s got 0x%08h, expected 0x%08h", $time, what, got, want);
    endtask

    // Drop valid and wait until every result has come back.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(logic [2:0] where, logic [31:0] value);
        settle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= where;
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (where == ADDR_HEAP_START) cfg_start = value;
        else                          cfg_end   = value;
    endtask

    task automatic offer_request(logic kind, logic [SIZE_W-1:0] size, logic [ADDR_W-1:0] addr,
                                 logic typed, heap_res_t fixed);
        int        gap;
        heap_res_t want;
        gap = 0;
        while ($urandom_range(0, 99) < send_idle_pct) gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {addr, size};
        do @(posedge aclk); while (!s_tready);
        want = apply_request(kind, size, addr);
        awaited_results.push_back(typed ? fixed : want);
    endtask

    // Mostly legal alloc/free traffic that swings between filling and draining the tables.
    task automatic run_random(int count, int s_idle, int r_idle, bit wide_sizes,
                              int hold_at, int pause_at);
        int                n;
        int                i;
        int                roll;
        int                cnt;
        bit                filling;
        logic              kind;
        logic [SIZE_W-1:0] size;
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] picks [LIVE_SLOTS];
        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        filling       = 1'b0;
        for (n = 0; n < count; n++) begin
            if (n == hold_at) hold_len = HOLD_CYCLES;
            if (n == pause_at) settle();
            if (n % 40 == 0) filling = !filling;
            roll = $urandom_range(0, 99);
            size = SIZE_W'($urandom_range(0, 24'hFF_FFFF));
            addr = $urandom();
            if (roll < 4) begin
                kind = REQ_ALLOC;
                size = '0;
            end else if (roll < 8) begin
                kind = REQ_FREE;
                addr = '0;
            end else if (roll < 13) begin
                kind = REQ_FREE;    // foreign address
            end else if ($urandom_range(0, 99) < (filling ? 75 : 25)) begin
                kind = REQ_ALLOC;
                if (!wide_sizes) begin
                    roll = $urandom_range(0, 99);
                    if (roll < 70)      size = SIZE_W'($urandom_range(1, 64));
                    else if (roll < 92) size = SIZE_W'($urandom_range(1, 4096));
                    else                size = SIZE_W'($urandom_range(1, 65535));
                end
            end else begin
                kind = REQ_FREE;
                cnt  = 0;
                for (i = 0; i < LIVE_SLOTS; i++)
                    if (live_ok[i]) begin
                        picks[cnt] = live_addr[i];
                        cnt++;
                    end
                if (cnt > 0)           addr = picks[$urandom_range(0, cnt - 1)];
                else if (free_cnt > 0) addr = free_addr[$urandom_range(0, free_cnt - 1)];
            end
            offer_request(kind, size, addr, 1'b0, '0);
        end
    endtask

    initial begin : result_sink
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_len > 0) begin
                m_tready <= 1'b0;
                repeat (hold_len) @(posedge aclk);
                hold_len = 0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge aclk) begin : result_check
        heap_res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (awaited_results.size() == 0) begin
                report_mismatch("unexpected beat, granted_address", m_tdata[ADDR_W-1:0], '0);
            end else begin
                want = awaited_results.pop_front();
                if (m_tdata[ADDR_W-1:0] !== want.granted)
                    report_mismatch("granted_address", m_tdata[ADDR_W-1:0], want.granted);
                if (m_tdata[ADDR_W +: STATUS_W] !== want.status)
                    report_mismatch("status", 32'(m_tdata[ADDR_W +: STATUS_W]),
                                    32'(want.status));
            end
        end
    end

    always @(posedge aclk) begin : watchdog
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("[first_fit_heap_allocator_top] ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        aresetn  = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = REQ_ALLOC;
        plan = '{
            set_reg(ROW_SET_START, 32'h0000_0000),
            set_reg(ROW_SET_END,   32'h0000_0000),
            ask_for(REQ_ALLOC, 24'd0,       32'hFFFF_FFFF, 32'd0, ST_NULL),
            ask_for(REQ_FREE,  24'hFF_FFFF, 32'd0,         32'd0, ST_NULL),
            ask_for(REQ_ALLOC, 24'd1,       32'd0,         32'd0, ST_OOM),
            ask_for(REQ_FREE,  24'd0,       32'hFFFF_FFFF, 32'd0, ST_UNKNOWN),
            ask_for(REQ_ALLOC, 24'hFF_FFFF, 32'd0,         32'd0, ST_OOM),
            // break still zero, so the new start is picked up
            set_reg(ROW_SET_START, 32'hFE00_0000),
            set_reg(ROW_SET_END,   32'hFFFF_FFFF),
            ask_for(REQ_ALLOC, 24'hFF_FFFF, 32'd0, 32'hFE00_0008, ST_OK),
            ask_for(REQ_ALLOC, 24'hFF_FFFF, 32'd0, 32'd0, ST_OOM),    // sum passes 2^32
            ask    (REQ_ALLOC, 24'd1,  32'd0),
            ask_for(REQ_FREE,  24'd0,  32'hFE00_0008, 32'd0, ST_OK),
            ask    (REQ_ALLOC, 24'h10, 32'd0),                        // reuse, no split
            ask    (REQ_FREE,  24'd0,  32'hFE00_0008),
            ask_for(REQ_FREE,  24'd0,  32'hFE00_0008, 32'd0, ST_UNKNOWN),
            ask    (REQ_FREE,  24'd0,  32'hFF00_000F),
            ask    (REQ_ALLOC, 24'd2,  32'd0),                        // newest too small
            ask    (REQ_ALLOC, 24'd1,  32'd0),
            set_reg(ROW_SET_END, 32'hFF00_0100),
            ask    (REQ_ALLOC, 24'hE8, 32'd0),                        // lands exactly on end
            ask_for(REQ_ALLOC, 24'd1,  32'd0, 32'd0, ST_OOM),
            set_reg(ROW_SET_END, 32'hFFFF_FFFF),
            ask    (REQ_FREE,  24'd0,  32'hFF00_0018)
        };
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (plan[i]) begin
            case (plan[i].op)
                ROW_SET_START: write_reg(ADDR_HEAP_START, plan[i].word);
                ROW_SET_END:   write_reg(ADDR_HEAP_END, plan[i].word);
                default: begin
                    offer_request(plan[i].kind, plan[i].size, plan[i].word,
                                  plan[i].typed, plan[i].res);
                end
            endcase
        end

        run_random(550, 16, 84, 1'b0, 120, -1);
        // tight heap for full-width sizes
        write_reg(ADDR_HEAP_END, brk + 32'h400);
        write_reg(ADDR_HEAP_START, 32'hFFFF_FFFF);
        run_random(150, 84, 16, 1'b1, -1, -1);
        write_reg(ADDR_HEAP_END, 32'hFFFF_FFFF);
        write_reg(ADDR_HEAP_START, 32'h0000_1000);
        run_random(400, 84, 16, 1'b0, -1, 200);
        write_reg(ADDR_HEAP_START, 32'h0000_0000);
        run_random(530, 0, 0, 1'b0, -1, -1);

        settle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (errors == 0) begin
            $display("[first_fit_heap_allocator_top] OK");
        end else begin
            $display("[first_fit_heap_allocator_top] ERROR");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/ffha_pkg.sv
hdl/ffha_ram.sv
hdl/ffha_cfg.sv
hdl/ffha_cmp.sv
hdl/ffha_seq.sv
hdl/first_fit_heap_allocator_top.sv
tb/sv/tb_first_fit_heap_allocator_top.sv
